@@ rtl/glmd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the grid local maximum detector.
// No dependencies; glmd_peak_fifo and the top level use it by scoped names.
package glmd_pkg;

    // Line buffer geometry
    localparam int MAX_COLS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int COLS_W   = COL_W + 1;
    localparam int ROW_W    = 16;
    localparam int SAMPLE_W = 32;
    localparam int TDATA_OUT_W = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = CFG_INDEX_W'(1);

    // Peak queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // Sign flip turns two's complement into an order-preserving unsigned key
    localparam logic [SAMPLE_W-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Which cells of one sample turned out to be peaks, in output order
    typedef struct packed {
        logic corner;      // cell (r, c), last cell of the grid
        logic left_cell;   // cell (r, c-1) of the last row
        logic upper_cell;  // cell (r-1, c)
    } peak_flags_t;

    // One sample's worth of decisions, pushed into the peak queue
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        peak_flags_t      flags;
    } peak_bundle_t;

endpackage

@@ rtl/glmd_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during a write to the same address returns the old contents.
module glmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/glmd_peak_fifo.sv @@
`timescale 1ns / 1ps
// Peak queue: holds per-sample peak bundles and unrolls each into one
// result transfer per set flag. Depends on glmd_pkg.
module glmd_peak_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  glmd_pkg::peak_bundle_t        push_data,
    output logic [glmd_pkg::Q_CNT_W-1:0]  level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [glmd_pkg::ROW_W-1:0]    out_row,
    output logic [glmd_pkg::COL_W-1:0]    out_col,
    output logic                          out_last
);

    glmd_pkg::peak_bundle_t            q_mem [glmd_pkg::Q_DEPTH];
    logic [glmd_pkg::Q_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [glmd_pkg::Q_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [glmd_pkg::Q_CNT_W-1:0]      count_reg, count_next;
    glmd_pkg::peak_flags_t             done_reg, done_next;
    glmd_pkg::peak_bundle_t            head;
    glmd_pkg::peak_flags_t             pending;
    glmd_pkg::peak_flags_t             pick;
    glmd_pkg::peak_flags_t             rest;
    logic                              xfer;
    logic                              pop;

    assign head    = q_mem[rd_ptr_reg];
    assign pending = head.flags & ~done_reg;

    // Pick the first pending result in output order
    always_comb
    begin
        pick = '0;
        if (pending.upper_cell)
        begin
            pick.upper_cell = 1'b1;
        end
        else if (pending.left_cell)
        begin
            pick.left_cell = 1'b1;
        end
        else
        begin
            pick.corner = 1'b1;
        end
    end

    assign rest     = pending & ~pick;
    assign out_last = (rest == '0);

    // Form the coordinates of the picked cell
    always_comb
    begin
        out_row = head.row;
        out_col = head.col;
        if (pick.upper_cell)
        begin
            out_row = head.row - glmd_pkg::ROW_W'(1);
        end
        else if (pick.left_cell)
        begin
            out_col = head.col - glmd_pkg::COL_W'(1);
        end
    end

    assign out_valid = (count_reg != '0);
    assign xfer      = out_valid & out_ready;
    assign pop       = xfer & out_last;
    assign level     = count_reg;

    // Advance pointers, count and the emitted-flag mask
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + glmd_pkg::Q_PTR_W'(1);
        end
        if (xfer)
        begin
            if (pop)
            begin
                rd_ptr_next = rd_ptr_reg + glmd_pkg::Q_PTR_W'(1);
                done_next   = '0;
            end
            else
            begin
                done_next = done_reg | pick;
            end
        end
        if (push && !pop)
        begin
            count_next = count_reg + glmd_pkg::Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - glmd_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            done_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    // Store incoming bundles
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/grid_local_maximum_detector.sv @@
`timescale 1ns / 1ps
// Four-neighbour local maximum detector over a streamed grid.
// Uses glmd_pkg, two glmd_ram line buffers and the glmd_peak_fifo result queue.
//
// Usage:
//   s_axis carries one signed 32-bit sample per transfer, row-major order.
//   m_axis carries one peak per transfer: row in tdata[15:0], column in
//   tdata[25:16]; tlast marks the last peak caused by one input sample.
//   The cfg channel writes grid_rows (index 0) and grid_cols (index 1);
//   either write restarts the grid at row 0, column 0. Other indexes are
//   ignored. cfg_ready is always high; write only while the block is idle.
// Timing:
//   An accepted sample is registered into the decision stage, whose peak
//   bundle is pushed into the result queue that presents the peaks.
//   Samples are taken one per cycle while the result queue has room; each
//   peak is one output transfer, and the four-bundle queue sets how far
//   input may run ahead of a stalled or slow receiver. When the queue plus
//   the sample in flight fill it, s_axis_tready drops until peaks drain.
//   Line buffer rows are read in the cycle before the decision; a write and
//   a read of the same entry in one cycle are bypassed.
// Reset:
//   rst_n clears the counters, the queue and the grid size to 1 x 1.
//   Line buffers are not cleared; unwritten entries never decide a peak.
module grid_local_maximum_detector (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream; tdata: sample[31:0]
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [glmd_pkg::SAMPLE_W-1:0]     s_axis_tdata,
    // Output stream; tdata: peak_row[15:0], peak_col[25:16], zero[31:26]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [glmd_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast,
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [glmd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [glmd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SW  = glmd_pkg::SAMPLE_W;
    localparam int CW  = glmd_pkg::COL_W;
    localparam int RW  = glmd_pkg::ROW_W;

    // Configuration and position counters
    logic [RW-1:0]    rows_m1_reg, rows_m1_next;
    logic [CW-1:0]    cols_m1_reg, cols_m1_next;
    logic [RW-1:0]    row_cnt_reg, row_cnt_next;
    logic [CW-1:0]    col_cnt_reg, col_cnt_next;
    logic             cfg_hit;
    logic [glmd_pkg::COLS_W-1:0] cols_raw;

    // Sample history: hist0 newest
    logic [SW-1:0]    hist0_reg, hist1_reg, hist2_reg;
    logic [SW-1:0]    key;

    // Decision stage
    logic             s1_valid_reg;
    logic [RW-1:0]    s1_row_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s1_last_row_reg;
    logic             s1_last_col_reg;
    logic             fwd_a_reg, fwd_b_reg;
    logic [2*SW-1:0]  fwd_a_data_reg;
    logic [SW-1:0]    fwd_b_data_reg;
    logic [SW-1:0]    prev_mid_reg;

    logic             accept;
    logic             last_row, last_col;
    logic [CW-1:0]    col_plus1;
    logic [2*SW-1:0]  ram_a_rdata, a_word, a_wdata;
    logic [SW-1:0]    ram_b_rdata;
    logic [SW-1:0]    s_cur, mid, up, right, upleft, left1, left2;
    logic             r_ge1, r_ge2, c_ge1, c_ge2;
    glmd_pkg::peak_flags_t  flags;
    glmd_pkg::peak_bundle_t bundle;
    logic [glmd_pkg::Q_CNT_W-1:0] q_level;
    logic [RW-1:0]    out_row;
    logic [CW-1:0]    out_col;

    assign cfg_ready = 1'b1;
    assign accept    = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (q_level + glmd_pkg::Q_CNT_W'(s1_valid_reg))
                           < glmd_pkg::Q_CNT_W'(glmd_pkg::Q_DEPTH);

    assign last_row  = (row_cnt_reg >= rows_m1_reg);
    assign last_col  = (col_cnt_reg >= cols_m1_reg);
    assign col_plus1 = col_cnt_reg + CW'(1);
    assign key       = s_axis_tdata ^ glmd_pkg::SIGN_FLIP;
    assign cfg_hit   = cfg_valid && ((cfg_index == glmd_pkg::REG_GRID_ROWS)
                                  || (cfg_index == glmd_pkg::REG_GRID_COLS));
    assign cols_raw  = cfg_data[glmd_pkg::COLS_W-1:0];

    // Apply register writes and advance the grid position
    always_comb
    begin
        rows_m1_next = rows_m1_reg;
        cols_m1_next = cols_m1_reg;
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (cfg_valid && (cfg_index == glmd_pkg::REG_GRID_ROWS))
        begin
            rows_m1_next = (cfg_data[RW-1:0] == '0) ? '0 : cfg_data[RW-1:0] - RW'(1);
        end
        if (cfg_valid && (cfg_index == glmd_pkg::REG_GRID_COLS))
        begin
            if (cols_raw == '0)
            begin
                cols_m1_next = '0;
            end
            else if (cols_raw > glmd_pkg::COLS_W'(glmd_pkg::MAX_COLS))
            begin
                cols_m1_next = CW'(glmd_pkg::MAX_COLS - 1);
            end
            else
            begin
                cols_m1_next = CW'(cols_raw - glmd_pkg::COLS_W'(1));
            end
        end
        if (cfg_hit)
        begin
            row_cnt_next = '0;
            col_cnt_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = last_row ? '0 : row_cnt_reg + RW'(1);
            end
            else
            begin
                col_cnt_next = col_plus1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m1_reg  <= '0;
            cols_m1_reg  <= '0;
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            fwd_a_reg    <= 1'b0;
            fwd_b_reg    <= 1'b0;
        end
        else
        begin
            rows_m1_reg  <= rows_m1_next;
            cols_m1_reg  <= cols_m1_next;
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
            s1_valid_reg <= accept;
            if (accept)
            begin
                // Bypass a line buffer entry written in this same cycle
                fwd_a_reg <= s1_valid_reg && (s1_col_reg == col_cnt_reg);
                fwd_b_reg <= s1_valid_reg && (s1_col_reg == col_plus1);
            end
        end
    end

    // Capture the sample, its position and bypass data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist0_reg       <= key;
            hist1_reg       <= hist0_reg;
            hist2_reg       <= hist1_reg;
            s1_row_reg      <= row_cnt_reg;
            s1_col_reg      <= col_cnt_reg;
            s1_last_row_reg <= last_row;
            s1_last_col_reg <= last_col;
            fwd_a_data_reg  <= a_wdata;
            fwd_b_data_reg  <= hist0_reg;
        end
        if (s1_valid_reg)
        begin
            prev_mid_reg <= mid;
        end
    end

    // Line buffer A: {row above, two rows above} per column
    glmd_ram #(
        .WIDTH (2 * SW),
        .DEPTH (glmd_pkg::MAX_COLS)
    ) u_ram_a (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (a_wdata),
        .re    (accept),
        .raddr (col_cnt_reg),
        .rdata (ram_a_rdata)
    );

    // Line buffer B: copy of the row above, read one column ahead
    glmd_ram #(
        .WIDTH (SW),
        .DEPTH (glmd_pkg::MAX_COLS)
    ) u_ram_b (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (hist0_reg),
        .re    (accept),
        .raddr (col_plus1),
        .rdata (ram_b_rdata)
    );

    // Gather the neighbourhood of the current cell
    assign a_word  = fwd_a_reg ? fwd_a_data_reg : ram_a_rdata;
    assign mid     = a_word[2*SW-1:SW];
    assign up      = a_word[SW-1:0];
    assign right   = fwd_b_reg ? fwd_b_data_reg : ram_b_rdata;
    assign upleft  = prev_mid_reg;
    assign s_cur   = hist0_reg;
    assign left1   = hist1_reg;
    assign left2   = hist2_reg;
    assign a_wdata = {s_cur, mid};

    assign r_ge1 = (s1_row_reg != '0);
    assign r_ge2 = (s1_row_reg > RW'(1));
    assign c_ge1 = (s1_col_reg != '0);
    assign c_ge2 = (s1_col_reg > CW'(1));

    // Decide the cell above, the cell to the left and the final corner
    always_comb
    begin
        flags.upper_cell = r_ge1 && (mid >= s_cur)
                           && (!r_ge2 || (mid >= up))
                           && (!c_ge1 || (mid >= upleft))
                           && (s1_last_col_reg || (mid >= right));
        flags.left_cell  = s1_last_row_reg && c_ge1 && (left1 >= s_cur)
                           && (!c_ge2 || (left1 >= left2))
                           && (!r_ge1 || (left1 >= upleft));
        flags.corner     = s1_last_row_reg && s1_last_col_reg
                           && (!c_ge1 || (s_cur >= left1))
                           && (!r_ge1 || (s_cur >= mid));
    end

    assign bundle.row   = s1_row_reg;
    assign bundle.col   = s1_col_reg;
    assign bundle.flags = flags;

    glmd_peak_fifo u_peak_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg && (flags != '0)),
        .push_data (bundle),
        .level     (q_level),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_last  (m_axis_tlast)
    );

    // Pack the result fields, low bits first
    assign m_axis_tdata = {(glmd_pkg::TDATA_OUT_W - RW - CW)'(0), out_col, out_row};

endmodule
